### src/buim_pkg.sv
// Package for the busy/idle utilization monitor.
// Holds field widths, register indexes, fixed constants and the divider
// request/result types; used by buim_div and the top level.
package buim_pkg;

  // Field widths
  localparam int TS_W   = 64;   // time stamps and accumulators
  localparam int PER_W  = 40;   // log period register
  localparam int BP_W   = 14;   // usage in basis points
  localparam int CNT_W  = 6;    // counts the 64 bit positions of a serial pass
  localparam int OUT_W  = 208;  // result beat, padded to whole bytes
  localparam int DATA_W = 64;   // configuration data bus

  // Usage full scale and reset window length
  localparam logic [BP_W-1:0]  USAGE_SCALE = 14'd10000;
  localparam logic [PER_W-1:0] PER_RESET   = 40'd60000000;

  // Register indexes (decoded from address bit 3)
  localparam logic REG_REVERSE = 1'b0;
  localparam logic REG_PERIOD  = 1'b1;

  // Event kinds
  localparam logic OP_START = 1'b0;
  localparam logic OP_STOP  = 1'b1;

  // Request to the serial divider: 78-bit dividend split in high and low
  typedef struct packed {
    logic              start;
    logic [BP_W-1:0]   hi;
    logic [TS_W-1:0]   lo;
    logic [TS_W-1:0]   dvs;
  } div_req_t;

  // Result of the serial divider, rounded to nearest
  typedef struct packed {
    logic            done;
    logic [BP_W-1:0] quo;
  } div_res_t;

endpackage

### src/buim_div.sv
// Radix-2 serial divider for the usage figure: one quotient bit per cycle.
// Takes a dividend whose high part is below the divisor; rounds to nearest.
// Depends on buim_pkg.
module buim_div (
  input  logic              clk,
  input  logic              rst_n,
  input  buim_pkg::div_req_t req,
  output buim_pkg::div_res_t res
);

  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_RUN  = 2'd1;
  localparam logic [1:0] DV_RND  = 2'd2;

  logic [1:0]                     dstate_r;
  logic [buim_pkg::CNT_W-1:0]     cnt_r;
  logic [buim_pkg::TS_W-1:0]      rem_r;
  logic [buim_pkg::TS_W-1:0]      lo_r;
  logic [buim_pkg::TS_W-1:0]      dvs_r;
  logic [buim_pkg::BP_W-1:0]      quo_r;
  logic [buim_pkg::BP_W-1:0]      quo_out_r;
  logic                           done_r;

  logic [buim_pkg::TS_W:0]        rem_sh;
  logic [buim_pkg::TS_W+1:0]      diff;
  logic                           ge;
  logic                           rnd_up;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    rem_sh = {rem_r, lo_r[buim_pkg::TS_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
    ge     = ~diff[buim_pkg::TS_W+1];
    rnd_up = ({rem_r, 1'b0} >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dstate_r <= DV_IDLE;
      done_r   <= 1'b0;
    end else begin
      // Flag the result for one cycle after the rounding step
      done_r <= (dstate_r == DV_RND);
      case (dstate_r)
        DV_IDLE: begin
          if (req.start) begin
            rem_r    <= {{(buim_pkg::TS_W-buim_pkg::BP_W){1'b0}}, req.hi};
            lo_r     <= req.lo;
            dvs_r    <= req.dvs;
            quo_r    <= '0;
            cnt_r    <= '0;
            dstate_r <= DV_RUN;
          end
        end
        DV_RUN: begin
          // Quotient stays below 2^14, so bits shifted out the top are zero
          rem_r <= ge ? diff[buim_pkg::TS_W-1:0] : rem_sh[buim_pkg::TS_W-1:0];
          lo_r  <= {lo_r[buim_pkg::TS_W-2:0], 1'b0};
          quo_r <= {quo_r[buim_pkg::BP_W-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == {buim_pkg::CNT_W{1'b1}}) begin
            dstate_r <= DV_RND;
          end
        end
        DV_RND: begin
          // Round half up: remainder at least half the divisor
          quo_out_r <= quo_r + buim_pkg::BP_W'(rnd_up);
          dstate_r  <= DV_IDLE;
        end
        default: dstate_r <= DV_IDLE;
      endcase
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_out_r;

endmodule

### src/busy_idle_utilization_monitor_unit.sv
// Busy/idle utilization monitor: bit-serial event arithmetic, serial divider.
// Every event runs one serial pass (LSB first) and then an evaluate step; a new
// event is accepted only in idle. A stop that closes a window with a nonzero
// total runs the serial divider (skipped when the share is at full scale) and
// then loads the output register once it is free.
// Synchronous active-low reset clears the registers, time stamps, accumulators
// and output valid; the log period resets to 60000000 us.
module busy_idle_utilization_monitor_unit (
  input  logic         clk,
  input  logic         rst_n,
  // Input beats
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // [63:0] time_us
  input  logic [0:0]   in_tuser,   // [0] op_code
  // Result beats
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [207:0] out_tdata,  // [63:0] window_total_us, [127:64] busy_us,
                                   // [191:128] idle_us, [205:192] usage_basis_points
  // Configuration (address bits below bit 3 are not decoded)
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int TW = buim_pkg::TS_W;
  localparam int PW = buim_pkg::PER_W;
  localparam int BW = buim_pkg::BP_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PASS = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]                 state_r;
  logic [buim_pkg::CNT_W-1:0] cnt_r;

  // Configuration
  logic          reverse_r;
  logic [PW-1:0] period_r;

  // Architectural state, rotated one bit a cycle during a pass
  logic [TW-1:0] start_r, stop_r, win_r, busy_r, idle_r;
  logic          start_nz_r, stop_nz_r, win_nz_r;

  // Event operands and pass working registers
  logic [TW-1:0] t_r, tot_r;
  logic [PW-1:0] per_r;
  logic          op_r, t_nz_r, base_nz_r;
  logic          c_sub_r, c_acc_r, c_tot_r, c_win_r, lt_r, tot_nz_r;

  // Result holding and output register
  logic [TW-1:0]  res_tot_r, res_busy_r, res_idle_r;
  logic [BW-1:0]  usage_r;
  logic [207:0]   out_data_r;
  logic           out_tvalid_r;

  // Serial datapath bits
  logic tb, bb, ab, ob, db, bor_nxt, eb, sb, c_acc_nxt, xb, c_tot_nxt;
  logic wb, c_win_nxt, lt_nxt;

  logic                       cfg_wr;
  logic [TW-1:0]              share;
  logic                       share_ge;
  logic [TW+BW-1:0]           prod;
  logic                       closing;
  buim_pkg::div_req_t         div_req;
  buim_pkg::div_res_t         div_res;

  // One bit of each serial adder: elapsed time, accumulator, total, window end
  always_comb begin
    tb = t_r[0];
    bb = (op_r == buim_pkg::OP_STOP) ? start_r[0] : stop_r[0];
    ab = (op_r == buim_pkg::OP_STOP) ? busy_r[0] : idle_r[0];
    ob = (op_r == buim_pkg::OP_STOP) ? idle_r[0] : busy_r[0];
    db        = tb ^ bb ^ c_sub_r;
    bor_nxt   = (~tb & bb) | (~(tb ^ bb) & c_sub_r);
    eb        = db & base_nz_r;
    sb        = ab ^ eb ^ c_acc_r;
    c_acc_nxt = (ab & eb) | (ab & c_acc_r) | (eb & c_acc_r);
    xb        = sb ^ ob ^ c_tot_r;
    c_tot_nxt = (sb & ob) | (sb & c_tot_r) | (ob & c_tot_r);
    wb        = win_r[0] ^ per_r[0] ^ c_win_r;
    c_win_nxt = (win_r[0] & per_r[0]) | (win_r[0] & c_win_r) | (per_r[0] & c_win_r);
    // LSB-first compare: the highest differing bit decides window end < time
    lt_nxt    = (wb != tb) ? tb : lt_r;
  end

  // Share, saturation test and scaled dividend for a closing window
  always_comb begin
    share    = reverse_r ? idle_r : busy_r;
    share_ge = (share >= tot_r);
    prod     = {{BW{1'b0}}, share} * {{TW{1'b0}}, buim_pkg::USAGE_SCALE};
    closing  = (state_r == ST_EVAL) && (op_r == buim_pkg::OP_STOP) && lt_r;
  end

  assign div_req.start = closing && tot_nz_r && !share_ge;
  assign div_req.hi    = prod[TW+BW-1:TW];
  assign div_req.lo    = prod[TW-1:0];
  assign div_req.dvs   = tot_r;

  buim_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[3] == buim_pkg::REG_PERIOD) ?
                      {{(buim_pkg::DATA_W-PW){1'b0}}, period_r} :
                      {{(buim_pkg::DATA_W-1){1'b0}}, reverse_r};

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      reverse_r    <= 1'b0;
      period_r     <= buim_pkg::PER_RESET;
      start_r      <= '0;
      stop_r       <= '0;
      win_r        <= '0;
      busy_r       <= '0;
      idle_r       <= '0;
      start_nz_r   <= 1'b0;
      stop_nz_r    <= 1'b0;
      win_nz_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // Write configuration registers
      if (cfg_wr) begin
        if (cfg_paddr[3] == buim_pkg::REG_PERIOD) begin
          period_r <= cfg_pwdata[PW-1:0];
        end else begin
          reverse_r <= cfg_pwdata[0];
        end
      end

      // Drop the result once its beat is taken, unless a new one follows
      if (out_tvalid_r && out_tready && (state_r != ST_FIN)) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            t_r       <= in_tdata;
            op_r      <= in_tuser[0];
            t_nz_r    <= |in_tdata;
            per_r     <= period_r;
            base_nz_r <= (in_tuser[0] == buim_pkg::OP_STOP) ? start_nz_r : stop_nz_r;
            c_sub_r   <= 1'b0;
            c_acc_r   <= 1'b0;
            c_tot_r   <= 1'b0;
            c_win_r   <= 1'b0;
            lt_r      <= 1'b0;
            tot_nz_r  <= 1'b0;
            cnt_r     <= '0;
            // Record the event time; the pass reads only the other stamp
            if (in_tuser[0] == buim_pkg::OP_STOP) begin
              stop_r    <= in_tdata;
              stop_nz_r <= |in_tdata;
            end else begin
              start_r    <= in_tdata;
              start_nz_r <= |in_tdata;
            end
            state_r <= ST_PASS;
          end
        end

        ST_PASS: begin
          // Advance every serial register by one bit
          t_r     <= {tb, t_r[TW-1:1]};
          start_r <= {start_r[0], start_r[TW-1:1]};
          stop_r  <= {stop_r[0], stop_r[TW-1:1]};
          win_r   <= {win_r[0], win_r[TW-1:1]};
          per_r   <= {1'b0, per_r[PW-1:1]};
          tot_r   <= {xb, tot_r[TW-1:1]};
          if (op_r == buim_pkg::OP_STOP) begin
            busy_r <= {sb, busy_r[TW-1:1]};
            idle_r <= {idle_r[0], idle_r[TW-1:1]};
          end else begin
            busy_r <= {busy_r[0], busy_r[TW-1:1]};
            idle_r <= {sb, idle_r[TW-1:1]};
          end
          c_sub_r  <= bor_nxt;
          c_acc_r  <= c_acc_nxt;
          c_tot_r  <= c_tot_nxt;
          c_win_r  <= c_win_nxt;
          lt_r     <= lt_nxt;
          tot_nz_r <= tot_nz_r | xb;
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == {buim_pkg::CNT_W{1'b1}}) begin
            state_r <= ST_EVAL;
          end
        end

        ST_EVAL: begin
          if (op_r == buim_pkg::OP_START) begin
            // Open a window if none is open
            if (!win_nz_r) begin
              win_r    <= t_r;
              win_nz_r <= t_nz_r;
            end
            state_r <= ST_IDLE;
          end else if (lt_r) begin
            // Close the window: hold the figures, restart at this stop
            res_tot_r  <= tot_r;
            res_busy_r <= busy_r;
            res_idle_r <= idle_r;
            win_r      <= t_r;
            win_nz_r   <= t_nz_r;
            busy_r     <= '0;
            idle_r     <= '0;
            if (!tot_nz_r) begin
              state_r <= ST_IDLE;
            end else if (share_ge) begin
              usage_r <= buim_pkg::USAGE_SCALE;
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_DIV;
            end
          end else begin
            state_r <= ST_IDLE;
          end
        end

        ST_DIV: begin
          if (div_res.done) begin
            usage_r <= div_res.quo;
            state_r <= ST_FIN;
          end
        end

        ST_FIN: begin
          // Load the output register once it is free
          if (!out_tvalid_r || out_tready) begin
            out_data_r   <= {2'b00, usage_r, res_idle_r, res_busy_r, res_tot_r};
            out_tvalid_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Divider reports only while the top waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == ST_DIV)
    else $error("divider result outside divide state");

  // A pass ends only after all 64 bit positions
  a_pass_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> $past(cnt_r) == {buim_pkg::CNT_W{1'b1}})
    else $error("serial pass ended early");

  // A closing stop leaves both accumulators cleared
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    closing |=> (busy_r == '0) && (idle_r == '0))
    else $error("accumulators not cleared on window close");

  // Usage never exceeds full scale
  a_usage_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> out_data_r[205:192] <= buim_pkg::USAGE_SCALE)
    else $error("usage above full scale");

endmodule
